### src/stack_calculator_execute_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the stack calculator
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef STACK_CALCULATOR_EXECUTE_MACROS_SVH
`define STACK_CALCULATOR_EXECUTE_MACROS_SVH

// Same-cycle implication
`define SCALC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define SCALC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/scalc_pkg.sv
// ----------------------------------------------------------------------------
// scalc_pkg
// Opcodes, status codes, sequencer states and Q32.32 helpers.
// ----------------------------------------------------------------------------
package scalc_pkg;

	localparam int STACK_ENTRIES_DEF = 64;
	localparam int DIV_STEPS = 96;

	localparam logic [63:0] Q_ONE = 64'h0000_0001_0000_0000;
	localparam logic [63:0] Q_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] Q_MIN = 64'h8000_0000_0000_0000;

	typedef enum logic [3:0] {
		OP_PUSH   = 4'd0,
		OP_POP    = 4'd1,
		OP_DUP    = 4'd2,
		OP_SWAP   = 4'd3,
		OP_CHECK  = 4'd4,
		OP_ADD    = 4'd5,
		OP_SUB    = 4'd6,
		OP_DIV    = 4'd7,
		OP_MUL    = 4'd8,
		OP_CMP_EQ = 4'd9
	} op_t;

	typedef enum logic [2:0] {
		STS_OK          = 3'd0,
		STS_UNDERFLOW   = 3'd1,
		STS_OVERFLOW    = 3'd2,
		STS_DIV_ZERO    = 3'd3,
		STS_ASSERT_FAIL = 3'd4,
		STS_BAD_OP      = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_MUL,
		S_DIV
	} state_t;

	// Magnitude of a two's complement value; the most negative value maps to 2^63.
	function automatic logic [63:0] mag64(input logic [63:0] v);
		mag64 = v[63] ? (64'd0 - v) : v;
	endfunction

	// Apply sign to a magnitude, clamping to the Q32.32 range.
	function automatic logic [63:0] sat_sign(input logic neg, input logic big,
			input logic [63:0] mag);
		logic [63:0] lim;
		logic [63:0] m;
		lim = neg ? Q_MIN : Q_MAX;
		m = (big || (mag > lim)) ? lim : mag;
		sat_sign = neg ? (64'd0 - m) : m;
	endfunction

endpackage

### src/scalc_stack_mem.sv
// ----------------------------------------------------------------------------
// scalc_stack_mem
// Value store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module scalc_stack_mem #(
	parameter int ENTRIES = scalc_pkg::STACK_ENTRIES_DEF
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [$clog2(ENTRIES)-1:0] wr_addr,
	input  logic [63:0]                wr_data,
	input  logic                       rd_en,
	input  logic [$clog2(ENTRIES)-1:0] rd_addr,
	output logic [63:0]                rd_data
);
	import scalc_pkg::*;

	logic [63:0] mem [ENTRIES];
	logic [63:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### src/scalc_mul.sv
// ----------------------------------------------------------------------------
// scalc_mul
// Saturating Q32.32 multiply from four 32x32 partial products.
// ----------------------------------------------------------------------------
module scalc_mul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        done,
	output logic [63:0] result
);
	import scalc_pkg::*;

	logic [63:0]  ua_q, ub_q;
	logic         neg_q;
	logic [2:0]   cnt_q;
	logic         run_q, done_q;
	logic [63:0]  pp_q;
	logic [1:0]   pp_sh_q;
	logic [127:0] acc_q;
	logic [1:0]   k;
	logic [31:0]  half_a, half_b;
	logic [127:0] pp_ext;

	assign k      = cnt_q[1:0];
	assign half_a = k[1] ? ua_q[63:32] : ua_q[31:0];
	assign half_b = k[0] ? ub_q[63:32] : ub_q[31:0];
	assign pp_ext = {64'd0, pp_q} << {pp_sh_q, 5'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 3'd1;
			if (cnt_q == 3'd5) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Products issue on counts 0..3 and accumulate on counts 1..4.
	always_ff @(posedge clk) begin
		if (start) begin
			ua_q  <= mag64(a);
			ub_q  <= mag64(b);
			neg_q <= a[63] ^ b[63];
			acc_q <= '0;
		end else if (run_q) begin
			if (cnt_q < 3'd4) begin
				pp_q    <= half_a * half_b;
				pp_sh_q <= {1'b0, k[1]} + {1'b0, k[0]};
			end
			if (cnt_q >= 3'd1 && cnt_q <= 3'd4) begin
				acc_q <= acc_q + pp_ext;
			end
		end
	end

	assign done   = done_q;
	assign result = sat_sign(neg_q, acc_q[127:96] != 32'd0, acc_q[95:32]);

endmodule

### src/scalc_div.sv
// ----------------------------------------------------------------------------
// scalc_div
// Saturating Q32.32 divide, restoring radix 2, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module scalc_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        done,
	output logic [63:0] result
);
	import scalc_pkg::*;

	localparam int CW = $clog2(DIV_STEPS);

	logic [63:0]   ub_q;
	logic          neg_q;
	logic [95:0]   n_q;
	logic [63:0]   r_q;
	logic [CW-1:0] cnt_q;
	logic          run_q, done_q;
	logic [64:0]   rs, diff;
	logic          ge;

	assign rs   = {r_q, n_q[95]};
	assign ge   = rs >= {1'b0, ub_q};
	assign diff = rs - {1'b0, ub_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + CW'(1);
			if (cnt_q == CW'(DIV_STEPS - 1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Dividend bits shift out the top while quotient bits shift in below.
	always_ff @(posedge clk) begin
		if (start) begin
			ub_q  <= mag64(b);
			neg_q <= a[63] ^ b[63];
			n_q   <= {mag64(a), 32'd0};
			r_q   <= '0;
		end else if (run_q) begin
			r_q <= ge ? diff[63:0] : rs[63:0];
			n_q <= {n_q[94:0], ge};
		end
	end

	assign done   = done_q;
	assign result = sat_sign(neg_q, n_q[95:64] != 32'd0, n_q[63:0]);

endmodule

### src/stack_calculator_execute.sv
// ----------------------------------------------------------------------------
// stack_calculator_execute
// Stack calculator execute unit on a Q32.32 value stack.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Beat contents (low bit first)
//  s_*      in   op[3:0], push_value[67:4], zero pad to 72 bits
//  m_*      out  status[2:0], top_value[66:3], stack_depth[73:67], pad to 80
//
//  Push, pop, dup, swap, assert, add, sub, equal: accept the beat, then
//  execute it with the second entry from the store's registered read port.
//  Multiply: four 32x32 partial products, one per cycle.
//  Divide: 96 restoring steps, one quotient bit per cycle.
//  Reset clears depth and output valid; the store needs no clearing.
//  A stalled output holds the finished result while the next beat is
//  accepted; that beat's commit waits until the output register frees.
//
`include "stack_calculator_execute_macros.svh"

module stack_calculator_execute #(
	parameter int STACK_ENTRIES = scalc_pkg::STACK_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // op[3:0], push_value[67:4]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata    // status[2:0], top_value[66:3], stack_depth[73:67]
);
	import scalc_pkg::*;

	localparam int AW = $clog2(STACK_ENTRIES);
	localparam int DW = $clog2(STACK_ENTRIES + 1);

	state_t        state_q, state_nxt;
	op_t           op_s1;
	logic [63:0]   imm_s1;
	logic [DW-1:0] depth_q;
	logic [63:0]   top_q;

	logic          out_valid_q;
	status_t       out_status_q;
	logic [63:0]   out_top_q;
	logic [6:0]    out_depth_q;

	logic          accept, out_free, commit;
	logic          mul_start, div_start, mul_done, div_done;
	logic [63:0]   mul_res, div_res, second;

	logic          has1, has2, full;
	logic [DW-1:0] dm1, dm2;
	status_t       c_status;
	logic [DW-1:0] c_depth;
	logic [63:0]   c_top, alu_res, sum, dif;
	logic          c_wr;
	logic [AW-1:0] c_waddr;
	logic [DW+6:0] depth_ext;

	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	assign has1 = depth_q != '0;
	assign has2 = depth_q >= DW'(2);
	assign full = depth_q == DW'(STACK_ENTRIES);
	assign dm1  = depth_q - DW'(1);
	assign dm2  = depth_q - DW'(2);

	// Read the entry below the top as the beat is accepted.
	scalc_stack_mem #(
		.ENTRIES (STACK_ENTRIES)
	) u_mem (
		.clk     (clk),
		.wr_en   (commit && c_wr),
		.wr_addr (c_waddr),
		.wr_data (top_q),
		.rd_en   (accept),
		.rd_addr (dm2[AW-1:0]),
		.rd_data (second)
	);

	scalc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (second),
		.b      (top_q),
		.done   (mul_done),
		.result (mul_res)
	);

	scalc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.a      (second),
		.b      (top_q),
		.done   (div_done),
		.result (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Sequencer: accept, execute, then wait on the multicycle unit if needed.
	always_comb begin
		state_nxt = state_q;
		s_tready  = 1'b0;
		commit    = 1'b0;
		mul_start = 1'b0;
		div_start = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				if (op_s1 == OP_MUL && has2) begin
					mul_start = 1'b1;
					state_nxt = S_MUL;
				end else if (op_s1 == OP_DIV && has2 && top_q != 64'd0) begin
					div_start = 1'b1;
					state_nxt = S_DIV;
				end else if (out_free) begin
					commit    = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			S_MUL: begin
				if (mul_done && out_free) begin
					commit    = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			S_DIV: begin
				if (div_done && out_free) begin
					commit    = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// Saturating add and subtract, equal as 1.0 or 0.0.
	assign sum = second + top_q;
	assign dif = second - top_q;

	always_comb begin
		case (op_s1)
			OP_ADD: begin
				if (second[63] == top_q[63] && sum[63] != second[63]) begin
					alu_res = second[63] ? Q_MIN : Q_MAX;
				end else begin
					alu_res = sum;
				end
			end
			OP_SUB: begin
				if (second[63] != top_q[63] && dif[63] != second[63]) begin
					alu_res = second[63] ? Q_MIN : Q_MAX;
				end else begin
					alu_res = dif;
				end
			end
			OP_MUL:    alu_res = mul_res;
			OP_DIV:    alu_res = div_res;
			OP_CMP_EQ: alu_res = (second == top_q) ? Q_ONE : 64'd0;
			default:   alu_res = 64'd0;
		endcase
	end

	// Outcome of the beat. The top lives in top_q; the store holds the
	// entries below it, so each beat writes at most one entry.
	always_comb begin
		c_status = STS_OK;
		c_depth  = depth_q;
		c_top    = top_q;
		c_wr     = 1'b0;
		c_waddr  = dm1[AW-1:0];
		case (op_s1)
			OP_PUSH: begin
				if (full) begin
					c_status = STS_OVERFLOW;
				end else begin
					c_wr    = has1;
					c_top   = imm_s1;
					c_depth = depth_q + DW'(1);
				end
			end
			OP_POP: begin
				if (!has1) begin
					c_status = STS_UNDERFLOW;
				end else begin
					c_top   = second;
					c_depth = dm1;
				end
			end
			OP_DUP: begin
				if (!has1) begin
					c_status = STS_UNDERFLOW;
				end else if (full) begin
					c_status = STS_OVERFLOW;
				end else begin
					c_wr    = 1'b1;
					c_depth = depth_q + DW'(1);
				end
			end
			OP_SWAP: begin
				if (!has2) begin
					c_status = STS_UNDERFLOW;
				end else begin
					c_wr    = 1'b1;
					c_waddr = dm2[AW-1:0];
					c_top   = second;
				end
			end
			OP_CHECK: begin
				if (!has1) begin
					c_status = STS_UNDERFLOW;
				end else if (top_q == 64'd0) begin
					c_status = STS_ASSERT_FAIL;
				end
			end
			OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_CMP_EQ: begin
				if (!has2) begin
					c_status = STS_UNDERFLOW;
				end else if (op_s1 == OP_DIV && top_q == 64'd0) begin
					c_status = STS_DIV_ZERO;
				end else begin
					c_top   = alu_res;
					c_depth = dm1;
				end
			end
			default: begin
				c_status = STS_BAD_OP;
			end
		endcase
	end

	// Latch the instruction on accept.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1  <= op_t'(s_tdata[3:0]);
			imm_s1 <= s_tdata[67:4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
		end else if (commit) begin
			depth_q <= c_depth;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			top_q <= c_top;
		end
	end

	// Output register: load on commit, drop valid once the beat is taken.
	assign depth_ext = {7'd0, c_depth};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_status_q <= c_status;
			out_top_q    <= (c_depth != '0) ? c_top : 64'd0;
			out_depth_q  <= depth_ext[6:0];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_depth_q, out_top_q, out_status_q};

	`SCALC_ASSERT_NOW(a_depth_bound, 1'b1, depth_q <= DW'(STACK_ENTRIES), "stack depth beyond capacity")
	`SCALC_ASSERT_NEXT(a_error_keeps_depth, commit && c_status != STS_OK, depth_q == $past(depth_q), "error changed the depth")
	`SCALC_ASSERT_NOW(a_commit_needs_room, commit, !out_valid_q || m_tready, "result overwrote a pending beat")
	`SCALC_ASSERT_NOW(a_single_unit, mul_start || div_start, state_q == S_EXEC && !(mul_start && div_start), "unit started outside execute")

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// Stack calculator execute unit testbench
// Drives opcode beats, predicts status, top and depth per beat, and compares
// every output beat in order against the predicted queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
	import scalc_pkg::*;

	localparam int DEPTH_MAX = 64;
	localparam int IDLE_LIMIT = 20000;

	typedef struct packed {
		logic [2:0]  status;
		logic [63:0] top;
		logic [6:0]  depth;
	} calc_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;   // op[3:0], push_value[67:4]
	logic        m_tvalid;
	logic        m_tready;
	logic [79:0] m_tdata;   // status[2:0], top_value[66:3], stack_depth[73:67]

	// Predictor state
	logic [63:0]  shadow_stack [DEPTH_MAX];
	int           shadow_depth;
	calc_result_t pending_results[$];

	int mismatches;
	int beats_sent;
	int beats_checked;
	int idle_cycles;
	int src_gap_pct;
	int sink_stall_pct;
	int op_hist [16];

	stack_calculator_execute dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Clamp a sign and a wide magnitude into Q32.32.
	function automatic logic [63:0] clamp_q(input logic neg, input logic [127:0] mag);
		logic [127:0] lim;
		logic [63:0]  m;
		lim = neg ? 128'h8000_0000_0000_0000 : 128'h7FFF_FFFF_FFFF_FFFF;
		m = (mag > lim) ? lim[63:0] : mag[63:0];
		return neg ? (64'd0 - m) : m;
	endfunction

	function automatic logic [63:0] abs_q(input logic [63:0] v);
		return v[63] ? (64'd0 - v) : v;
	endfunction

	function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b,
			input logic subtract);
		logic signed [64:0] s;
		s = subtract ? ($signed({a[63], a}) - $signed({b[63], b}))
			: ($signed({a[63], a}) + $signed({b[63], b}));
		if (s > $signed({1'b0, Q_MAX}))
			return Q_MAX;
		if (s < $signed({1'b1, Q_MIN}))
			return Q_MIN;
		return s[63:0];
	endfunction

	// Work out one beat's result and advance the shadow stack.
	function automatic calc_result_t execute_op(input logic [3:0] op, input logic [63:0] imm);
		calc_result_t r;
		logic [63:0]  a, b, v;
		logic [127:0] wide;
		logic         neg;
		r.status = STS_OK;
		a = (shadow_depth >= 2) ? shadow_stack[shadow_depth-2] : 64'd0;
		b = (shadow_depth >= 1) ? shadow_stack[shadow_depth-1] : 64'd0;
		neg = a[63] ^ b[63];
		case (op)
			OP_PUSH: begin
				if (shadow_depth >= DEPTH_MAX) r.status = STS_OVERFLOW;
				else begin
					shadow_stack[shadow_depth] = imm;
					shadow_depth++;
				end
			end
			OP_POP: begin
				if (shadow_depth < 1) r.status = STS_UNDERFLOW;
				else shadow_depth--;
			end
			OP_DUP: begin
				if (shadow_depth < 1) r.status = STS_UNDERFLOW;
				else if (shadow_depth >= DEPTH_MAX) r.status = STS_OVERFLOW;
				else begin
					shadow_stack[shadow_depth] = b;
					shadow_depth++;
				end
			end
			OP_SWAP: begin
				if (shadow_depth < 2) r.status = STS_UNDERFLOW;
				else begin
					shadow_stack[shadow_depth-1] = a;
					shadow_stack[shadow_depth-2] = b;
				end
			end
			OP_CHECK: begin
				if (shadow_depth < 1) r.status = STS_UNDERFLOW;
				else if (b == 64'd0) r.status = STS_ASSERT_FAIL;
			end
			OP_ADD, OP_SUB, OP_DIV, OP_MUL, OP_CMP_EQ: begin
				if (shadow_depth < 2) r.status = STS_UNDERFLOW;
				else if (op == OP_DIV && b == 64'd0) r.status = STS_DIV_ZERO;
				else begin
					case (op)
						OP_ADD: v = add_sat(a, b, 1'b0);
						OP_SUB: v = add_sat(a, b, 1'b1);
						OP_MUL: begin
							wide = ({64'd0, abs_q(a)} * {64'd0, abs_q(b)}) >> 32;
							v = clamp_q(neg, wide);
						end
						OP_DIV: begin
							wide = ({64'd0, abs_q(a)} << 32) / {64'd0, abs_q(b)};
							v = clamp_q(neg, wide);
						end
						default: v = (a == b) ? Q_ONE : 64'd0;
					endcase
					shadow_stack[shadow_depth-2] = v;
					shadow_depth--;
				end
			end
			default: r.status = STS_BAD_OP;
		endcase
		r.top = (shadow_depth > 0) ? shadow_stack[shadow_depth-1] : 64'd0;
		r.depth = shadow_depth[6:0];
		return r;
	endfunction

	// Send one beat; the prediction is queued at the accepting edge.
	// Valid stays high after the beat until the next gap or drain drops it.
	task automatic send_beat(input logic [3:0] op, input logic [63:0] imm);
		while ($urandom_range(99) < src_gap_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tdata <= {4'd0, imm, op};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(execute_op(op, imm));
		op_hist[op]++;
		beats_sent++;
		@(negedge clk);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (120) @(negedge clk);
	endtask

	// Check every output beat against the oldest prediction.
	always @(posedge clk) begin
		calc_result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[2:0], m_tdata[66:3], m_tdata[73:67]};
			beats_checked++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected output beat %h", got);
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status || got.top !== want.top
						|| got.depth !== want.depth) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: status %0d/%0d top %h/%h depth %0d/%0d",
							want.status, got.status, want.top, got.top,
							want.depth, got.depth);
				end
			end
		end
	end

	// Randomize the sink stall each cycle.
	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= sink_stall_pct);

	// Watchdog on input accept and output handshake activity.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL stack_calculator_execute");
			$finish;
		end
	end

	function automatic logic [63:0] rand_q();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(5))
			0: v = Q_MAX;
			1: v = Q_MIN;
			2: v = 64'd0;
			3: v = {{32{v[63]}}, v[31:0]} << $urandom_range(32);
			default: ;
		endcase
		return v;
	endfunction

	task automatic test_directed();
		send_beat(OP_POP, 64'd0);
		send_beat(OP_DUP, 64'd0);
		send_beat(OP_CHECK, 64'd0);
		send_beat(OP_ADD, 64'd0);
		send_beat(OP_PUSH, 64'd0);
		send_beat(OP_SWAP, 64'd0);
		send_beat(OP_CHECK, 64'd0);
		send_beat(OP_PUSH, Q_MAX);
		send_beat(OP_PUSH, Q_MAX);
		send_beat(OP_ADD, 64'd0);
		send_beat(OP_PUSH, Q_MIN);
		send_beat(OP_MUL, 64'd0);
		send_beat(OP_PUSH, Q_MIN);
		send_beat(OP_SUB, 64'd0);
		send_beat(OP_DUP, 64'd0);
		send_beat(OP_CMP_EQ, 64'd0);
		send_beat(OP_PUSH, 64'd0);
		send_beat(OP_DIV, 64'd0);
		send_beat(OP_PUSH, 64'h0000_0000_0000_0001);
		send_beat(OP_DIV, 64'd0);
		send_beat(OP_CHECK, 64'd0);
		send_beat(4'd10, 64'hFFFF_FFFF_FFFF_FFFF);
		send_beat(4'd15, 64'd0);
		drain_results();
	endtask

	// Fill to the top, try to overflow, then empty again.
	task automatic test_full_stack();
		while (shadow_depth < DEPTH_MAX)
			send_beat(OP_PUSH, rand_q());
		send_beat(OP_PUSH, 64'd5);
		send_beat(OP_DUP, 64'd0);
		send_beat(OP_SWAP, 64'd0);
		while (shadow_depth > 0)
			send_beat(OP_POP, 64'd0);
		drain_results();
	endtask

	task automatic test_random(input int count);
		logic [3:0] op;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(9) == 0)
				op = 4'($urandom_range(15));
			else if (shadow_depth < 2 || $urandom_range(3) == 0)
				op = ($urandom_range(2) == 0) ? OP_DUP : OP_PUSH;
			else if (shadow_depth > 50)
				op = 4'($urandom_range(OP_ADD, OP_CMP_EQ));
			else
				op = 4'($urandom_range(OP_POP, OP_CMP_EQ));
			// Keep long divides rare.
			if (op == OP_DIV && $urandom_range(2) != 0)
				op = OP_MUL;
			send_beat(op, rand_q());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		shadow_depth = 0;
		mismatches = 0;
		beats_sent = 0;
		beats_checked = 0;
		src_gap_pct = 6;
		sink_stall_pct = 67;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_full_stack();
		test_random(250);
		// Hold off until everything is out, then swap idle roles.
		drain_results();
		src_gap_pct = 67;
		sink_stall_pct = 6;
		test_random(250);
		src_gap_pct = 0;
		sink_stall_pct = 0;
		test_random(250);
		drain_results();
		$display("Ran %0d beats (%0d checked): pushes %0d, muls %0d, divs %0d,",
			beats_sent, beats_checked, op_hist[OP_PUSH], op_hist[OP_MUL], op_hist[OP_DIV]);
		$display("full-stack overflow, underflow, saturation and bad opcodes covered.");
		if (mismatches == 0 && pending_results.size() == 0)
			$display("PASS stack_calculator_execute");
		else
			$display("FAIL stack_calculator_execute");
		$finish;
	end

endmodule
